// ----- design/clt_pkg.sv -----
// Package: scanner mode codes, token kinds, error codes, config indexes, character class helpers.
package clt_pkg;
	localparam int POS_WIDTH_DEF = 24;
	localparam int LEN_WIDTH_DEF = 12;

	localparam logic [3:0] M_IDLE = 4'd0;
	localparam logic [3:0] M_LINE = 4'd1;
	localparam logic [3:0] M_BLOCK = 4'd2;
	localparam logic [3:0] M_BSTAR = 4'd3;
	localparam logic [3:0] M_IDENT = 4'd4;
	localparam logic [3:0] M_NUM = 4'd5;
	localparam logic [3:0] M_SYM1 = 4'd6;
	localparam logic [3:0] M_SYM2 = 4'd7;
	localparam logic [3:0] M_COPEN = 4'd8;
	localparam logic [3:0] M_CESC = 4'd9;
	localparam logic [3:0] M_CCLOSE = 4'd10;
	localparam logic [3:0] M_STR = 4'd11;
	localparam logic [3:0] M_SESC = 4'd12;

	localparam logic [3:0] K_IDENT = 4'd0;
	localparam logic [3:0] K_TRUE = 4'd1;
	localparam logic [3:0] K_FALSE = 4'd2;
	localparam logic [3:0] K_DEC = 4'd3;
	localparam logic [3:0] K_HEX = 4'd4;
	localparam logic [3:0] K_FLOAT = 4'd5;
	localparam logic [3:0] K_CHAR = 4'd6;
	localparam logic [3:0] K_STRING = 4'd7;
	localparam logic [3:0] K_SYMBOL = 4'd8;
	localparam logic [3:0] K_END = 4'd9;

	localparam logic [2:0] E_NONE = 3'd0;
	localparam logic [2:0] E_COMMENT = 3'd1;
	localparam logic [2:0] E_NAME = 3'd2;
	localparam logic [2:0] E_NUMBER = 3'd3;
	localparam logic [2:0] E_CHAR = 3'd4;
	localparam logic [2:0] E_STR_OPEN = 3'd5;
	localparam logic [2:0] E_STR_LONG = 3'd6;

	localparam logic [1:0] R_START_LINE = 2'd0;
	localparam logic [1:0] R_MAX_NAME = 2'd1;
	localparam logic [1:0] R_MAX_STRING = 2'd2;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic pairs_with(input logic [7:0] h, input logic [7:0] c);
		logic r;
		r = 1'b0;
		case ({h, c})
			"<<", ">>", "!=", "<=", ">=", "++", "--", "+=", "-=", "*=", "/=", "&&", "||",
			"^^", "==", "**", "~=", "::": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction
endpackage

// ----- design/c_like_tokenizer_unit.sv -----
// Top level: streaming C-like tokenizer, one character per request.
//
//  channel | signals                                        | role
//  in      | in_valid/in_ready, ch, end_of_text, no_constants, template_close | char request
//  out     | out_valid/out_ready, token_* , error_code, last_of_run | token request
//  cfg     | cfg_we, cfg_index, cfg_data                     | register writes
//
// One character per cycle while in_ready is high. A character updates the scanner state in the cycle
// it is taken and its results (up to two) land in a two-entry output queue.
// in_ready is high while the queue has room for two results, so a character
// can be taken in the same cycle the head result leaves.
// Reset clears the scanner to idle, position 0, line = 1, limits 1024.
// After an error result the scanner halts until reset; requests are still
// taken and dropped.
module c_like_tokenizer_unit #(
	parameter int POS_WIDTH = clt_pkg::POS_WIDTH_DEF,
	parameter int LEN_WIDTH = clt_pkg::LEN_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           ch,
	input  logic                 end_of_text,
	input  logic                 no_constants,
	input  logic                 template_close,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [3:0]           token_kind,
	output logic [POS_WIDTH-1:0] token_start,
	output logic [LEN_WIDTH-1:0] token_length,
	output logic [POS_WIDTH-1:0] token_line,
	output logic [2:0]           error_code,
	output logic                 last_of_run,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_data
);
	import clt_pkg::*;

	localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
	localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

	typedef struct packed {
		logic [3:0]           kind;
		logic [POS_WIDTH-1:0] start;
		logic [LEN_WIDTH-1:0] len;
		logic [POS_WIDTH-1:0] line;
		logic [2:0]           err;
		logic                 last;
	} tok_t;

	// config
	logic [LEN_WIDTH-1:0] max_name_q, max_str_q;

	// scanner state
	logic [3:0]           mode_q;
	logic [POS_WIDTH-1:0] pos_q, line_q, spos_q, sline_q;
	logic [LEN_WIDTH-1:0] len_q, esc_q;
	logic                 point_q, hexm_q, halted_q;
	logic [7:0]           held_q;
	logic [1:0]           bwm_q, flags_q;

	// output queue
	tok_t     q_q [2];
	logic [1:0] cnt_q;

	logic take;
	assign in_ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);
	assign take = in_valid && in_ready;

	// next-state
	logic [3:0]           mode_d;
	logic [POS_WIDTH-1:0] line_d, spos_d, sline_d;
	logic [LEN_WIDTH-1:0] len_d, esc_d, eff;
	logic                 point_d, hexm_d, halt_d;
	logic [7:0]           held_d, u;
	logic [1:0]           bwm_d, flags_d;
	tok_t                 r0, r1;
	logic [1:0]           nres;
	logic                 do_begin, do_finish, eot;
	logic [LEN_WIDTH-1:0] fin_len;
	logic [3:0]           fin_kind;
	logic [2:0]           fin_err;
	logic [LEN_WIDTH-1:0] len_inc;
	logic [POS_WIDTH-1:0] line_inc;
	logic [7:0]           lc;

	assign len_inc = (len_q == LEN_MAX) ? len_q : len_q + 1'b1;
	assign line_inc = (line_q == POS_MAX) ? line_q : line_q + 1'b1;

	// match one letter of true/false at index idx
	function automatic logic [1:0] match(input logic [1:0] m, input logic [7:0] c,
		input logic [LEN_WIDTH-1:0] idx);
		logic [7:0] l;
		logic [1:0] r;
		l = c | 8'h20;
		r = m;
		case (idx)
			0: begin if (l != "t") r[0] = 1'b0; if (l != "f") r[1] = 1'b0; end
			1: begin if (l != "r") r[0] = 1'b0; if (l != "a") r[1] = 1'b0; end
			2: begin if (l != "u") r[0] = 1'b0; if (l != "l") r[1] = 1'b0; end
			3: begin if (l != "e") r[0] = 1'b0; if (l != "s") r[1] = 1'b0; end
			4: begin r[0] = 1'b0; if (l != "e") r[1] = 1'b0; end
			default: r = 2'b00;
		endcase
		return r;
	endfunction

	always_comb begin
		mode_d = mode_q; line_d = line_q; spos_d = spos_q; sline_d = sline_q;
		len_d = len_q; esc_d = esc_q; point_d = point_q; hexm_d = hexm_q;
		held_d = held_q; bwm_d = bwm_q; flags_d = flags_q; halt_d = halted_q;
		r0 = '0; r1 = '0; nres = 2'd0;
		do_begin = 1'b0; do_finish = 1'b0;
		fin_len = len_q;
		eot = end_of_text || ch == 8'd0;
		u = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;
		lc = ch;
		eff = (esc_q > len_inc) ? '0 : len_inc - esc_q;
		// finish result for pending ident/num/sym
		fin_kind = K_SYMBOL; fin_err = E_NONE;
		if (mode_q == M_IDENT) begin
			fin_kind = K_IDENT;
			if (!flags_q[0]) begin
				if (len_q == LEN_WIDTH'(4) && bwm_q[0]) fin_kind = K_TRUE;
				else if (len_q == LEN_WIDTH'(5) && bwm_q[1]) fin_kind = K_FALSE;
			end
			fin_err = (len_q >= max_name_q) ? E_NAME : E_NONE;
		end else if (mode_q == M_NUM) begin
			fin_kind = point_q ? K_FLOAT : (hexm_q ? K_HEX : K_DEC);
			fin_err = (len_q >= max_name_q) ? E_NUMBER : E_NONE;
		end

		if (eot) begin
			case (mode_q)
				M_BLOCK, M_BSTAR: begin
					r0 = '{K_END, pos_q, '0, line_q, E_COMMENT, 1'b0}; nres = 2'd1;
				end
				M_IDENT, M_NUM, M_SYM1, M_SYM2: do_finish = 1'b1;
				M_COPEN, M_CESC, M_CCLOSE: begin
					r0 = '{K_CHAR, spos_q, len_q, sline_q, E_CHAR, 1'b0}; nres = 2'd1;
				end
				M_STR, M_SESC: begin
					r0 = '{K_STRING, spos_q, len_q, sline_q, E_STR_OPEN, 1'b0}; nres = 2'd1;
				end
				default: ;
			endcase
			if (do_finish) begin
				r0 = '{fin_kind, spos_q, len_q, sline_q, fin_err, 1'b0}; nres = 2'd1;
			end
			if (!(nres == 2'd1 && r0.err != E_NONE)) begin
				if (nres == 2'd1) begin
					r1 = '{K_END, pos_q, '0, line_q, E_NONE, 1'b0}; nres = 2'd2;
				end else begin
					r0 = '{K_END, pos_q, '0, line_q, E_NONE, 1'b0}; nres = 2'd1;
				end
				mode_d = M_IDLE;
			end
		end else begin
			case (mode_q)
				M_LINE: if (ch == 8'h0A) begin line_d = line_inc; mode_d = M_IDLE; end
				M_BLOCK: begin
					if (ch == 8'h0A) line_d = line_inc;
					else if (ch == "*") mode_d = M_BSTAR;
				end
				M_BSTAR: begin
					if (ch == "/") mode_d = M_IDLE;
					else if (ch != "*") begin
						if (ch == 8'h0A) line_d = line_inc;
						mode_d = M_BLOCK;
					end
				end
				M_IDENT: begin
					if (is_alpha(ch) || is_digit(ch)) begin
						bwm_d = match(bwm_q, lc, len_q); len_d = len_inc;
					end else begin
						do_finish = 1'b1; do_begin = fin_err == E_NONE;
					end
				end
				M_NUM: begin
					if (is_digit(u) || (!point_q && u == ".") || (!hexm_q && u == "X") ||
						(hexm_q && u >= "A" && u <= "F")) begin
						len_d = len_inc;
						if (u == ".") point_d = 1'b1;
						if (u == "X") hexm_d = 1'b1;
					end else if (point_q && u == "F") begin
						// suffix counts toward the length limit
						fin_len = len_inc; do_finish = 1'b1;
						fin_err = (len_inc >= max_name_q) ? E_NUMBER : E_NONE;
					end else begin
						do_finish = 1'b1; do_begin = fin_err == E_NONE;
					end
				end
				M_SYM1: begin
					if (held_q == "/" && ch == "*") mode_d = M_BLOCK;
					else if (held_q == "/" && ch == "/") mode_d = M_LINE;
					else if ((held_q == "+" || held_q == "-") && !flags_q[0] && is_digit(ch))
					begin
						len_d = len_inc; mode_d = M_NUM;
					end else if (pairs_with(held_q, ch) &&
						!(held_q == ">" && ch == ">" && flags_q[1])) begin
						len_d = len_inc;
						if (held_q == ">" && ch == ">") mode_d = M_SYM2;
						else begin fin_len = len_inc; do_finish = 1'b1; end
					end else begin
						do_finish = 1'b1; do_begin = 1'b1;
					end
				end
				M_SYM2: begin
					if (ch == ">") begin fin_len = len_inc; do_finish = 1'b1; end
					else begin do_finish = 1'b1; do_begin = 1'b1; end
				end
				M_COPEN: begin
					len_d = len_inc; mode_d = (ch == 8'h5C) ? M_CESC : M_CCLOSE;
				end
				M_CESC: begin len_d = len_inc; mode_d = M_CCLOSE; end
				M_CCLOSE: begin
					len_d = len_inc; mode_d = M_IDLE;
					r0 = '{K_CHAR, spos_q, len_inc, sline_q,
						(ch == 8'h27) ? E_NONE : E_CHAR, 1'b0};
					nres = 2'd1;
				end
				M_STR: begin
					len_d = len_inc;
					if (ch == 8'h22) begin
						mode_d = M_IDLE;
						r0 = '{K_STRING, spos_q, len_inc, sline_q,
							(eff >= max_str_q) ? E_STR_LONG : E_NONE, 1'b0};
						nres = 2'd1;
					end else if (ch == 8'h0A || ch == 8'h0D) begin
						mode_d = M_IDLE;
						r0 = '{K_STRING, spos_q, len_inc, sline_q, E_STR_OPEN, 1'b0};
						nres = 2'd1;
					end else if (ch == 8'h5C) mode_d = M_SESC;
				end
				M_SESC: begin
					len_d = len_inc;
					if (ch == 8'h0A || ch == 8'h0D) begin
						mode_d = M_IDLE;
						r0 = '{K_STRING, spos_q, len_inc, sline_q, E_STR_OPEN, 1'b0};
						nres = 2'd1;
					end else begin
						if (esc_q != LEN_MAX) esc_d = esc_q + 1'b1;
						mode_d = M_STR;
					end
				end
				default: do_begin = 1'b1;
			endcase
			if (do_finish) begin
				r0 = '{fin_kind, spos_q, fin_len, sline_q, fin_err, 1'b0};
				nres = 2'd1; mode_d = M_IDLE; len_d = fin_len;
			end
			if (do_begin) begin
				if (ch == 8'h0A) line_d = line_inc;
				else if (!(ch == " " || ch == 8'h09 || ch == 8'h0D)) begin
					spos_d = pos_q; sline_d = line_q; esc_d = '0;
					point_d = 1'b0; hexm_d = 1'b0; held_d = ch;
					flags_d = {template_close, no_constants};
					len_d = LEN_WIDTH'(1);
					bwm_d = 2'b11;
					if (is_alpha(ch)) begin
						bwm_d = match(2'b11, lc, '0); mode_d = M_IDENT;
					end else if (!no_constants && is_digit(ch)) mode_d = M_NUM;
					else if (ch == 8'h27) mode_d = M_COPEN;
					else if (ch == 8'h22) mode_d = M_STR;
					else mode_d = M_SYM1;
				end
			end
		end
		if (nres == 2'd1) begin
			r0.last = 1'b1;
			if (r0.err != E_NONE) halt_d = 1'b1;
		end
		if (nres == 2'd2) r1.last = 1'b1;
	end

	logic pop;
	assign pop = out_valid && out_ready;
	assign out_valid = cnt_q != 2'd0;
	assign token_kind = q_q[0].kind;
	assign token_start = q_q[0].start;
	assign token_length = q_q[0].len;
	assign token_line = q_q[0].line;
	assign error_code = q_q[0].err;
	assign last_of_run = q_q[0].last;

	logic [1:0] push_n;
	logic [1:0] after_pop;
	assign push_n = (take && !halted_q) ? nres : 2'd0;
	assign after_pop = cnt_q - {1'b0, pop};

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			if (after_pop == 2'd0) begin
				q_q[0] <= r0;
				q_q[1] <= r1;
			end else q_q[1] <= r0;
		end else if (pop) q_q[0] <= q_q[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			max_name_q <= LEN_WIDTH'(1024);
			max_str_q <= LEN_WIDTH'(1024);
			mode_q <= M_IDLE; pos_q <= '0; line_q <= POS_WIDTH'(1);
			spos_q <= '0; sline_q <= '0; len_q <= '0; esc_q <= '0;
			point_q <= 1'b0; hexm_q <= 1'b0; held_q <= '0; bwm_q <= '0;
			flags_q <= '0; halted_q <= 1'b0;
		end else begin
			cnt_q <= after_pop + push_n;
			if (take && !halted_q) begin
				mode_q <= mode_d; line_q <= line_d; spos_q <= spos_d; sline_q <= sline_d;
				len_q <= len_d; esc_q <= esc_d; point_q <= point_d; hexm_q <= hexm_d;
				held_q <= held_d; bwm_q <= bwm_d; flags_q <= flags_d; halted_q <= halt_d;
				if (!eot && pos_q != POS_MAX) pos_q <= pos_q + 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					R_START_LINE: line_q <= POS_WIDTH'(cfg_data);
					R_MAX_NAME: max_name_q <= LEN_WIDTH'(cfg_data[11:0]);
					R_MAX_STRING: max_str_q <= LEN_WIDTH'(cfg_data[11:0]);
					default: ;
				endcase
			end
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue overflow");
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halt released");
	a_halted_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> push_n == 2'd0) else $error("result while halted");
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !halted_q && eot) |=> $stable(pos_q)) else $error("end moved position");
endmodule

// ----- tb/tb.sv -----
// Testbench for the streaming tokenizer: random text against a built-in scanner predictor.
module tb;
	import clt_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam logic [23:0] POS_TOP = 24'hFFFFFF;
	localparam logic [11:0] LEN_TOP = 12'hFFF;
	localparam logic [31:0] WORD_T = "true";
	localparam logic [39:0] WORD_F = "false";

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
		logic       nc;
		logic       tc;
	} char_req_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [23:0] start;
		logic [11:0] len;
		logic [23:0] line;
		logic [2:0]  err;
		logic        last;
	} token_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] ch = '0;
	logic end_of_text = 1'b0;
	logic no_constants = 1'b0;
	logic template_close = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] token_kind;
	logic [23:0] token_start;
	logic [11:0] token_length;
	logic [23:0] token_line;
	logic [2:0] error_code;
	logic last_of_run;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	c_like_tokenizer_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.ch(ch), .end_of_text(end_of_text), .no_constants(no_constants),
		.template_close(template_close),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .token_start(token_start), .token_length(token_length),
		.token_line(token_line), .error_code(error_code), .last_of_run(last_of_run),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	char_req_t pending_chars[$];
	token_t expected_tokens[$];
	int mismatches = 0;
	int cycles = 0;
	int in_gap = 0;
	int out_gap = 0;
	int burst = 0;

	// Scanner model state, mirrors the block
	logic [3:0]  sc_mode;
	logic [23:0] sc_pos, sc_line, sc_tok_pos, sc_tok_line;
	logic [11:0] sc_len, sc_esc;
	logic        sc_point, sc_hex, sc_halt;
	logic [7:0]  sc_held;
	logic [1:0]  sc_word, sc_flags;
	logic [11:0] reg_name_max, reg_str_max;
	token_t      step_buf[2];
	int          step_cnt;

	// ---------------- predictor ----------------
	function automatic logic name_char(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
	endfunction

	function automatic logic digit_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function void scan_reset();
		reg_name_max = 12'd1024;
		reg_str_max = 12'd1024;
		sc_mode = M_IDLE;
		sc_pos = '0;
		sc_line = 24'd1;
		sc_tok_pos = '0;
		sc_tok_line = '0;
		sc_len = '0;
		sc_esc = '0;
		sc_point = 1'b0;
		sc_hex = 1'b0;
		sc_held = '0;
		sc_word = '0;
		sc_flags = '0;
		sc_halt = 1'b0;
	endfunction

	function void line_bump();
		if (sc_line != POS_TOP)
			sc_line = sc_line + 1'b1;
	endfunction

	function void len_bump();
		if (sc_len != LEN_TOP)
			sc_len = sc_len + 1'b1;
	endfunction

	function void put_token(input logic [3:0] k, input logic [23:0] st, input logic [11:0] l,
			input logic [23:0] ln, input logic [2:0] e);
		if (step_cnt >= 2)
			return;
		step_buf[step_cnt] = '{kind: k, start: st, len: l, line: ln, err: e, last: 1'b0};
		step_cnt++;
		if (e != E_NONE)
			sc_halt = 1'b1;
	endfunction

	function void close_token(input logic [3:0] k, input logic [2:0] e);
		put_token(k, sc_tok_pos, sc_len, sc_tok_line, e);
		sc_mode = M_IDLE;
	endfunction

	function void track_word(input logic [7:0] c);
		logic [7:0] lc;
		lc = c | 8'h20;
		if (sc_len >= 4 || lc != WORD_T[8*(3-sc_len[1:0]) +: 8])
			sc_word[0] = 1'b0;
		if (sc_len >= 5 || lc != WORD_F[8*(4-sc_len[2:0]) +: 8])
			sc_word[1] = 1'b0;
	endfunction

	function void flush_token();
		logic [3:0] k;
		if (sc_mode == M_IDENT) begin
			k = K_IDENT;
			if (!sc_flags[0]) begin
				if (sc_len == 4 && sc_word[0])
					k = K_TRUE;
				else if (sc_len == 5 && sc_word[1])
					k = K_FALSE;
			end
			close_token(k, sc_len >= reg_name_max ? E_NAME : E_NONE);
		end else if (sc_mode == M_NUM) begin
			k = sc_point ? K_FLOAT : (sc_hex ? K_HEX : K_DEC);
			close_token(k, sc_len >= reg_name_max ? E_NUMBER : E_NONE);
		end else begin
			close_token(K_SYMBOL, E_NONE);
		end
	endfunction

	function void open_token(input logic [7:0] c, input logic nc, input logic tc);
		if (c == "\n") begin
			line_bump();
			return;
		end
		if (c == " " || c == "\t" || c == "\r")
			return;
		sc_tok_pos = sc_pos;
		sc_tok_line = sc_line;
		sc_len = '0;
		sc_esc = '0;
		sc_point = 1'b0;
		sc_hex = 1'b0;
		sc_word = 2'b11;
		sc_held = c;
		sc_flags = {tc, nc};
		if (name_char(c)) begin
			track_word(c);
			sc_mode = M_IDENT;
		end else if (!nc && digit_char(c))
			sc_mode = M_NUM;
		else if (c == "'")
			sc_mode = M_COPEN;
		else if (c == "\"")
			sc_mode = M_STR;
		else
			sc_mode = M_SYM1;
		sc_len = 12'd1;
	endfunction

	function automatic logic sym_pair(input logic [7:0] h, input logic [7:0] c, input logic tc);
		if (h == ">" && c == ">" && tc)
			return 1'b0;
		case ({h, c})
			"<<", ">>", "!=", "<=", ">=", "++", "--", "+=", "-=", "*=", "/=", "&&", "||",
			"^^", "==", "**", "~=", "::": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function void scan_char(input logic [7:0] c, input logic nc, input logic tc);
		logic [7:0] u;
		logic [11:0] eff;
		u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
		case (sc_mode)
			M_LINE: begin
				if (c == "\n") begin
					line_bump();
					sc_mode = M_IDLE;
				end
			end
			M_BLOCK: begin
				if (c == "\n")
					line_bump();
				else if (c == "*")
					sc_mode = M_BSTAR;
			end
			M_BSTAR: begin
				if (c == "/")
					sc_mode = M_IDLE;
				else if (c != "*") begin
					if (c == "\n")
						line_bump();
					sc_mode = M_BLOCK;
				end
			end
			M_IDENT: begin
				if (name_char(c) || digit_char(c)) begin
					track_word(c);
					len_bump();
				end else begin
					flush_token();
					if (!sc_halt)
						open_token(c, nc, tc);
				end
			end
			M_NUM: begin
				if (digit_char(u) || (!sc_point && u == ".") || (!sc_hex && u == "X") ||
						(sc_hex && u >= "A" && u <= "F")) begin
					len_bump();
					if (u == ".")
						sc_point = 1'b1;
					if (u == "X")
						sc_hex = 1'b1;
				end else if (sc_point && u == "F") begin
					len_bump();
					flush_token();
				end else begin
					flush_token();
					if (!sc_halt)
						open_token(c, nc, tc);
				end
			end
			M_SYM1: begin
				if (sc_held == "/" && c == "*")
					sc_mode = M_BLOCK;
				else if (sc_held == "/" && c == "/")
					sc_mode = M_LINE;
				else if ((sc_held == "+" || sc_held == "-") && !sc_flags[0] && digit_char(c)) begin
					len_bump();
					sc_mode = M_NUM;
				end else if (sym_pair(sc_held, c, sc_flags[1])) begin
					len_bump();
					if (sc_held == ">" && c == ">")
						sc_mode = M_SYM2;
					else
						flush_token();
				end else begin
					flush_token();
					open_token(c, nc, tc);
				end
			end
			M_SYM2: begin
				if (c == ">") begin
					len_bump();
					flush_token();
				end else begin
					flush_token();
					open_token(c, nc, tc);
				end
			end
			M_COPEN: begin
				len_bump();
				sc_mode = (c == "\\") ? M_CESC : M_CCLOSE;
			end
			M_CESC: begin
				len_bump();
				sc_mode = M_CCLOSE;
			end
			M_CCLOSE: begin
				len_bump();
				close_token(K_CHAR, c == "'" ? E_NONE : E_CHAR);
			end
			M_STR: begin
				len_bump();
				if (c == "\"") begin
					eff = (sc_esc > sc_len) ? 12'd0 : sc_len - sc_esc;
					close_token(K_STRING, eff >= reg_str_max ? E_STR_LONG : E_NONE);
				end else if (c == "\n" || c == "\r")
					close_token(K_STRING, E_STR_OPEN);
				else if (c == "\\")
					sc_mode = M_SESC;
			end
			M_SESC: begin
				len_bump();
				if (c == "\n" || c == "\r")
					close_token(K_STRING, E_STR_OPEN);
				else begin
					if (sc_esc != LEN_TOP)
						sc_esc = sc_esc + 1'b1;
					sc_mode = M_STR;
				end
			end
			default: open_token(c, nc, tc);
		endcase
	endfunction

	function void scan_end();
		case (sc_mode)
			M_BLOCK, M_BSTAR: begin
				put_token(K_END, sc_pos, '0, sc_line, E_COMMENT);
				return;
			end
			M_IDENT, M_NUM, M_SYM1, M_SYM2: flush_token();
			M_COPEN, M_CESC, M_CCLOSE: close_token(K_CHAR, E_CHAR);
			M_STR, M_SESC: close_token(K_STRING, E_STR_OPEN);
			default: ;
		endcase
		if (sc_halt)
			return;
		put_token(K_END, sc_pos, '0, sc_line, E_NONE);
		sc_mode = M_IDLE;
	endfunction

	// Work out the tokens one accepted character request produces
	function void predict_tokens(input char_req_t r);
		step_cnt = 0;
		if (sc_halt)
			return;
		if (r.eot || r.ch == 8'd0)
			scan_end();
		else begin
			scan_char(r.ch, r.nc, r.tc);
			if (sc_pos != POS_TOP)
				sc_pos = sc_pos + 1'b1;
		end
		if (step_cnt > 0)
			step_buf[step_cnt-1].last = 1'b1;
		for (int i = 0; i < step_cnt; i++)
			expected_tokens.push_back(step_buf[i]);
	endfunction

	// ---------------- stimulus helpers ----------------
	// Mostly short gaps, some long, with bursts of no gaps at all
	function automatic int pick_gap();
		int r;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst = $urandom_range(20, 200);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	task automatic push_req(input logic [7:0] c, input logic e, input logic nc, input logic tc);
		pending_chars.push_back('{ch: c, eot: e, nc: nc, tc: tc});
	endtask

	task automatic push_chr(input logic [7:0] c);
		push_req(c, 1'b0, $urandom_range(0, 4) == 0, 1'($urandom_range(0, 1)));
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			push_chr(s[i]);
	endtask

	task automatic push_eot();
		if ($urandom_range(0, 1))
			push_req(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		else
			push_req(8'd0, 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	function automatic logic [7:0] pick_of(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	// Text byte for strings and char constants: any nonzero byte but the delimiters
	function automatic logic [7:0] text_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == "\"" || c == "\\" || c == "\n" || c == "\r" || c == "'");
		return c;
	endfunction

	// Harmless characters: never a quote, a slash or an end mark
	function automatic logic [7:0] noise_byte();
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return 8'($urandom_range(128, 255));
		if (r == 1)
			return pick_of("abcxyzABCFX_0123456789.");
		return pick_of("!#$%&()*+,-.:;<=>?@[]^`{|}~ \t\n\r");
	endfunction

	// One well-formed lexeme, skipped run or end mark, with random content
	task automatic push_lexeme();
		int n;
		int k;
		string w;
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				if ($urandom_range(0, 3) == 0) begin
					w = $urandom_range(0, 1) ? "true" : "false";
					for (int i = 0; i < w.len(); i++)
						push_chr($urandom_range(0, 1) ? (w[i] & 8'hDF) : w[i]);
				end else begin
					push_chr(pick_of("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
					n = $urandom_range(0, 7);
					repeat (n) push_chr(pick_of("azAZ_09fxTE"));
				end
			end
			3, 4, 5: begin
				if ($urandom_range(0, 4) == 0)
					push_chr(pick_of("+-"));
				k = $urandom_range(0, 2);
				if (k == 1) begin
					push_chr("0");
					push_chr(pick_of("xX"));
					repeat ($urandom_range(1, 4)) push_chr(pick_of("0123456789abcdefABCDEF"));
				end else begin
					repeat ($urandom_range(1, 4)) push_chr(pick_of("0123456789"));
					if (k == 2) begin
						push_chr(".");
						repeat ($urandom_range(0, 3)) push_chr(pick_of("0123456789"));
						if ($urandom_range(0, 1))
							push_chr(pick_of("fF"));
					end
				end
			end
			6, 7: begin
				push_chr("'");
				if ($urandom_range(0, 2) == 0) begin
					push_chr("\\");
					push_chr(8'($urandom_range(1, 255)));
				end else
					push_chr($urandom_range(0, 5) == 0 ? 8'h27 : text_byte());
				push_chr("'");
			end
			8, 9: begin
				push_chr("\"");
				repeat ($urandom_range(0, 10)) begin
					if ($urandom_range(0, 3) == 0) begin
						push_chr("\\");
						do
							n = $urandom_range(1, 255);
						while (n == 10 || n == 13);
						push_chr(8'(n));
					end else
						push_chr($urandom_range(0, 7) == 0 ? 8'h27 : text_byte());
				end
				push_chr("\"");
			end
			10, 11, 12: begin
				case ($urandom_range(0, 19))
					0: push_str("<<");
					1: push_str(">>");
					2: push_str(">>>");
					3: push_str("!=");
					4: push_str("<=");
					5: push_str(">=");
					6: push_str("++");
					7: push_str("--");
					8: push_str("+=");
					9: push_str("-=");
					10: push_str("*=");
					11: push_str("/=");
					12: push_str("&&");
					13: push_str("||");
					14: push_str("^^");
					15: push_str("==");
					16: push_str("**");
					17: push_str("~=");
					18: push_str("::");
					default: push_chr(noise_byte());
				endcase
			end
			13: repeat ($urandom_range(1, 4)) push_chr(pick_of(" \t\r\n\n"));
			14: begin
				// block comment; body has no slash so it cannot close early
				push_str("/*");
				repeat ($urandom_range(0, 8)) push_chr(pick_of("ab *\n*\t'\"x"));
				push_str("*/");
			end
			15: begin
				push_str("//");
				repeat ($urandom_range(0, 8)) push_chr(pick_of("ab */'\"\t/x"));
				push_chr("\n");
			end
			16: push_eot();
			default: repeat ($urandom_range(1, 3)) push_chr(noise_byte());
		endcase
	endtask

	task automatic push_text(input int lexemes);
		repeat (lexemes) begin
			push_lexeme();
			if ($urandom_range(0, 9) < 7)
				push_chr(pick_of(" \t\r\n"));
		end
		push_eot();
	endtask

	// Let the queues drain, then wait for results still in the block
	task automatic wait_drained();
		while (pending_chars.size() != 0 || in_valid || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			R_START_LINE: sc_line = val;
			R_MAX_NAME: reg_name_max = val[11:0];
			R_MAX_STRING: reg_str_max = val[11:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// ---------------- driver ----------------
	always @(posedge clk) begin
		char_req_t r;
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_tokens('{ch: ch, eot: end_of_text, nc: no_constants, tc: template_close});
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_chars.size() != 0) begin
					r = pending_chars.pop_front();
					ch <= r.ch;
					end_of_text <= r.eot;
					no_constants <= r.nc;
					template_close <= r.tc;
					in_valid <= 1'b1;
					in_gap <= pick_gap();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		token_t want;
		token_t got;
		int g;
		if (arst_n) begin
			g = out_gap;
			if (out_valid && out_ready) begin
				got = '{kind: token_kind, start: token_start, len: token_length,
					line: token_line, err: error_code, last: last_of_run};
				if (expected_tokens.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected token %p", got);
				end else begin
					want = expected_tokens.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("token mismatch: expected %p actual %p", want, got);
					end
				end
				g = pick_gap();
			end
			if (g > 0) begin
				out_ready <= 1'b0;
				out_gap <= g - 1;
			end else begin
				out_ready <= 1'b1;
				out_gap <= 0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("c_like_tokenizer_unit: mismatch");
			$finish;
		end
	end

	// ---------------- sequence ----------------
	initial begin
		scan_reset();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: bool words, hex, signed float, char, escaped string, shifts, comments
		push_str("TrUe fAlSe 0x1F -3.5f 'a' '\\n' \"a\\\"b\" >>> ~=::");
		push_req(">", 1'b0, 1'b0, 1'b1);
		push_str(">/*c*/\n//x\n");
		push_req("9", 1'b0, 1'b1, 1'b0);
		push_str("_q");
		push_eot();
		wait_drained();

		// high extremes; line saturates, long escaped string
		write_reg(R_START_LINE, 24'hFFFFFE);
		write_reg(R_MAX_NAME, 24'd4095);
		write_reg(R_MAX_STRING, 24'd4095);
		push_text(60);
		push_chr("\"");
		repeat (300) begin
			push_chr("\\");
			push_chr(text_byte());
		end
		push_chr("\"");
		push_eot();
		wait_drained();

		write_reg(R_START_LINE, 24'd0);
		write_reg(R_MAX_NAME, 24'd100);
		write_reg(R_MAX_STRING, 24'd100);
		write_reg(2'd3, 24'hFFFFFF);
		push_text(100);
		wait_drained();

		write_reg(R_START_LINE, 24'($urandom_range(0, 24'hFFFFFF)));
		write_reg(R_MAX_NAME, 24'($urandom_range(64, 4095)));
		write_reg(R_MAX_STRING, 24'($urandom_range(64, 4095)));
		push_text(100);
		wait_drained();

		// an error halts the block for good, so it comes last
		write_reg(R_MAX_NAME, 24'd1);
		write_reg(R_MAX_STRING, 24'd1);
		case ($urandom_range(0, 5))
			0: begin
				push_str("/* x");
				push_eot();
			end
			1: push_str("ab ");
			2: push_str("12 ");
			3: push_str("'ab");
			4: push_str("\"ab\n");
			default: push_str("\"ab\"");
		endcase
		repeat (20) push_chr(noise_byte());
		push_eot();
		wait_drained();
		repeat (20) @(posedge clk);

		if (expected_tokens.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("c_like_tokenizer_unit: match");
		else
			$display("c_like_tokenizer_unit: mismatch");
		$finish;
	end
endmodule
